>>> src/smm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the slot pool mailbox.
package smm_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_PUT   = 2'd1;
	localparam logic [1:0] OP_GET   = 2'd2;
	localparam logic [1:0] OP_FREE  = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_FREE    = 3'd1;
	localparam logic [2:0] ST_RING_EMPTY = 3'd2;
	localparam logic [2:0] ST_BAD_INDEX  = 3'd3;
	localparam logic [2:0] ST_RING_FULL  = 3'd4;
	localparam logic [2:0] ST_NOT_IN_USE = 3'd5;

	localparam logic [1:0] REG_ACTIVE_SLOTS = 2'd0;
	localparam logic [1:0] REG_SLOT_BYTES   = 2'd1;
	localparam logic [1:0] REG_POOL_BASE    = 2'd2;

	typedef struct packed {
		logic              alloc_en;
		logic              free_en;
		logic [SLOT_W-1:0] idx;
	} pool_cmd_t;

	typedef struct packed {
		logic              alloc_ok;
		logic [SLOT_W-1:0] alloc_slot;
		logic              idx_marked;
	} pool_info_t;

endpackage

>>> src/smm_ring_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with a registered read port.
module smm_ring_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/smm_mark_pool.sv
`timescale 1ns / 1ps
// In-use marks, used count and lowest-free-slot search.
module smm_mark_pool import smm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] cap,
	input  pool_cmd_t        cmd,
	output pool_info_t       info
);

	logic [MAX_SLOTS-1:0] marks_q;
	logic [CNT_W-1:0]     used_q;
	logic [MAX_SLOTS-1:0] free_vec;
	logic [SLOT_W-1:0]    low_slot;

	always_comb begin
		low_slot = '0;
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			free_vec[i] = !marks_q[i] && (CNT_W'(i) < cap);
			if (free_vec[i]) begin
				low_slot = SLOT_W'(i);
			end
		end
	end

	assign info.alloc_ok   = (used_q < cap) && (|free_vec);
	assign info.alloc_slot = low_slot;
	assign info.idx_marked = marks_q[cmd.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			used_q  <= '0;
		end else if (cmd.alloc_en && info.alloc_ok) begin
			marks_q[low_slot] <= 1'b1;
			used_q            <= used_q + CNT_W'(1);
		end else if (cmd.free_en) begin
			marks_q[cmd.idx] <= 1'b0;
			if (used_q != '0) begin
				used_q <= used_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> src/slot_pool_mailbox.sv
`timescale 1ns / 1ps
// Top level of the slot pool mailbox: config registers, ring control, result stage.
//
// Usage: operations enter on the op channel (opcode, slot_index) under op_valid
// and op_stall; one result per operation leaves on the res channel (status,
// result_slot, slot_address) under res_valid and res_stall. Registers are written
// through cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// Write registers only while no operation is outstanding.
// Timing: an accepted operation waits in the evaluation stage (valid_s1); its result
// is registered when the result register is free, and res_valid then stays high
// until the result transfers while res_stall is low.
// Flow: op_stall is high while an operation is in the evaluation stage, as set by the
// read-modify-write of ring RAM and mark flops, one operation in flight at a time.
// Stall: while res_stall holds a result, the evaluation stage waits and op_stall
// stays high while it holds an operation, so no operation is lost or reordered.
// Reset: marks, counts and ring pointers clear at once, registers take their
// defaults (64 slots, 64 bytes per slot, base 0); ring RAM contents stay
// undefined until written. No clearing pass is needed.
module slot_pool_mailbox import smm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_stall,
	input  logic [1:0]  opcode,
	input  logic [5:0]  slot_index,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic [5:0]  result_slot,
	output logic [31:0] slot_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [6:0]        active_q;
	logic [15:0]       bytes_q;
	logic [31:0]       base_q;
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0]  total_q;
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              res_valid_q;
	logic [2:0]        status_q;
	logic [SLOT_W-1:0] slot_q;

	logic [CNT_W-1:0]  cap;
	logic [SLOT_W-1:0] head_eff;
	logic [SLOT_W-1:0] tail_eff;
	logic [SLOT_W-1:0] head_nxt;
	logic [SLOT_W-1:0] tail_nxt;
	logic [SLOT_W-1:0] ring_rdata;
	logic              fire_s1;
	logic              idx_ok;
	logic              put_ok;
	logic              get_ok;
	logic              free_ok;
	logic [2:0]        status_c;
	logic [SLOT_W-1:0] slot_c;
	logic [21:0]       prod;
	pool_cmd_t         pool_cmd;
	pool_info_t        pool_info;

	assign cfg_ready = 1'b1;
	assign op_stall  = valid_s1;
	assign fire_s1   = valid_s1 && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 7'd64;
			bytes_q  <= 16'd64;
			base_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE_SLOTS: active_q <= cfg_data[6:0];
				REG_SLOT_BYTES:   bytes_q  <= cfg_data[15:0];
				REG_POOL_BASE:    base_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (active_q == '0) begin
			cap = CNT_W'(1);
		end else if (CNT_W'(active_q) > CNT_W'(MAX_SLOTS)) begin
			cap = CNT_W'(MAX_SLOTS);
		end else begin
			cap = CNT_W'(active_q);
		end
		head_eff = (CNT_W'(head_q) >= cap) ? '0 : head_q;
		tail_eff = (CNT_W'(tail_q) >= cap) ? '0 : tail_q;
		head_nxt = (CNT_W'(head_eff) + CNT_W'(1) >= cap) ? '0 : head_eff + SLOT_W'(1);
		tail_nxt = (CNT_W'(tail_eff) + CNT_W'(1) >= cap) ? '0 : tail_eff + SLOT_W'(1);
	end

	smm_ring_ram #(
		.DEPTH(MAX_SLOTS),
		.WIDTH(SLOT_W)
	) u_ring_ram (
		.clk  (clk),
		.we   (fire_s1 && put_ok),
		.waddr(tail_eff),
		.wdata(idx_s1),
		.raddr(head_eff),
		.rdata(ring_rdata)
	);

	assign pool_cmd.alloc_en = fire_s1 && (op_s1 == OP_ALLOC);
	assign pool_cmd.free_en  = fire_s1 && free_ok;
	assign pool_cmd.idx      = idx_s1;

	smm_mark_pool u_mark_pool (
		.clk   (clk),
		.arst_n(arst_n),
		.cap   (cap),
		.cmd   (pool_cmd),
		.info  (pool_info)
	);

	always_comb begin
		idx_ok   = CNT_W'(idx_s1) < cap;
		put_ok   = 1'b0;
		get_ok   = 1'b0;
		free_ok  = 1'b0;
		status_c = ST_OK;
		slot_c   = idx_s1;
		case (op_s1)
			OP_ALLOC: begin
				if (pool_info.alloc_ok) begin
					slot_c = pool_info.alloc_slot;
				end else begin
					status_c = ST_NO_FREE;
				end
			end
			OP_PUT: begin
				if (!idx_ok) begin
					status_c = ST_BAD_INDEX;
				end else if (total_q >= cap) begin
					status_c = ST_RING_FULL;
				end else begin
					put_ok = 1'b1;
				end
			end
			OP_GET: begin
				if (total_q == '0) begin
					status_c = ST_RING_EMPTY;
				end else begin
					get_ok = 1'b1;
					slot_c = ring_rdata;
				end
			end
			OP_FREE: begin
				if (!idx_ok) begin
					status_c = ST_BAD_INDEX;
				end else if (!pool_info.idx_marked) begin
					status_c = ST_NOT_IN_USE;
				end else begin
					free_ok = 1'b1;
				end
			end
			default: status_c = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			total_q  <= '0;
		end else begin
			if (op_valid && !op_stall) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				head_q <= get_ok ? head_nxt : head_eff;
				tail_q <= put_ok ? tail_nxt : tail_eff;
				if (put_ok) begin
					total_q <= total_q + CNT_W'(1);
				end else if (get_ok) begin
					total_q <= total_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && !op_stall) begin
			op_s1  <= opcode;
			idx_s1 <= slot_index;
		end
		if (fire_s1) begin
			status_q <= status_c;
			slot_q   <= slot_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign prod         = 22'(slot_q) * 22'(bytes_q);
	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign result_slot  = slot_q;
	assign slot_address = base_q + 32'(prod);

endmodule

>>> src/smm_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the slot pool mailbox and its bind.
module smm_checker import smm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        op_valid,
	input logic        op_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [2:0]  status,
	input logic [5:0]  result_slot,
	input logic [31:0] slot_address
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=>
			$stable(status) && $stable(result_slot) && $stable(slot_address))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status <= ST_NOT_IN_USE)
		else $error("undefined status code");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_stall |=> op_stall)
		else $error("second operation taken while one is in flight");

endmodule

bind slot_pool_mailbox smm_checker u_smm_checker (.*);
